@@ hw/rtl/tcirc_pkg.sv @@
// Shared types and status codes for the triangle circumcircle block.
`default_nettype none

package tcirc_pkg;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] third_x;
        logic signed [31:0] third_y;
    } tri_in_t;

    typedef struct packed {
        logic signed [63:0] center_x;
        logic signed [63:0] center_y;
        logic        [62:0] radius;
        logic        [1:0]  status;
    } tri_out_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_COLLINEAR = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/tcirc_div.sv @@
// Pipelined restoring divider: two unsigned quotients over one shared divisor.
`default_nettype none

module tcirc_div #(
    parameter int NW = 100,
    parameter int DW = 67,
    parameter int SW = 67
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num_a,
    input  wire logic [NW-1:0] num_b,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [NW-1:0]      quo_a,
    output logic [NW-1:0]      quo_b,
    output logic [SW-1:0]      side_out
);

    // One quotient bit per stage. The working word shifts the numerator out at the
    // top while the quotient bits fill in at the bottom.
    logic [NW-1:0] vld_reg;
    logic [DW-1:0] ra_reg   [NW];
    logic [DW-1:0] rb_reg   [NW];
    logic [NW-1:0] wa_reg   [NW];
    logic [NW-1:0] wb_reg   [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    logic [NW-1:0] vld_src;
    logic [DW-1:0] ra_src   [NW];
    logic [DW-1:0] rb_src   [NW];
    logic [NW-1:0] wa_src   [NW];
    logic [NW-1:0] wb_src   [NW];
    logic [DW-1:0] den_src  [NW];
    logic [SW-1:0] side_src [NW];

    logic [DW:0]   ta       [NW];
    logic [DW:0]   tb       [NW];
    logic          ga       [NW];
    logic          gb       [NW];
    logic [DW-1:0] ra_next  [NW];
    logic [DW-1:0] rb_next  [NW];
    logic [NW-1:0] wa_next  [NW];
    logic [NW-1:0] wb_next  [NW];

    always_comb
    begin
        vld_src[0]  = in_valid;
        ra_src[0]   = '0;
        rb_src[0]   = '0;
        wa_src[0]   = num_a;
        wb_src[0]   = num_b;
        den_src[0]  = den;
        side_src[0] = side_in;
        for (int k = 1; k < NW; k++)
        begin
            vld_src[k]  = vld_reg[k-1];
            ra_src[k]   = ra_reg[k-1];
            rb_src[k]   = rb_reg[k-1];
            wa_src[k]   = wa_reg[k-1];
            wb_src[k]   = wb_reg[k-1];
            den_src[k]  = den_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
        for (int k = 0; k < NW; k++)
        begin
            ta[k] = {ra_src[k], wa_src[k][NW-1]};
            tb[k] = {rb_src[k], wb_src[k][NW-1]};
            ga[k] = ta[k] >= {1'b0, den_src[k]};
            gb[k] = tb[k] >= {1'b0, den_src[k]};
            ra_next[k] = ga[k] ? DW'(ta[k] - {1'b0, den_src[k]}) : ta[k][DW-1:0];
            rb_next[k] = gb[k] ? DW'(tb[k] - {1'b0, den_src[k]}) : tb[k][DW-1:0];
            wa_next[k] = {wa_src[k][NW-2:0], ga[k]};
            wb_next[k] = {wb_src[k][NW-2:0], gb[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_src;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NW; k++)
        begin
            ra_reg[k]   <= ra_next[k];
            rb_reg[k]   <= rb_next[k];
            wa_reg[k]   <= wa_next[k];
            wb_reg[k]   <= wb_next[k];
            den_reg[k]  <= den_src[k];
            side_reg[k] <= side_src[k];
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quo_a     = wa_reg[NW-1];
    assign quo_b     = wb_reg[NW-1];
    assign side_out  = side_reg[NW-1];

endmodule

`default_nettype wire

@@ hw/rtl/triangle_circumcircle.sv @@
// Triangle circumcircle: center and radius of the circle through three vertices.
//
// A word of three vertices is taken on vertices at every rising edge where start
// is high and busy is low. The block is fully pipelined, so busy stays low and a
// new word may be offered in every cycle: one triangle per clock.
// The result word appears on result, marked by a one-cycle done strobe. The
// depth is set by the two shared-divisor quotients (100 stages, one quotient
// bit each) and the square root (64 stages, one root bit each), plus the
// stages of products and sums.
// Results leave in the order their inputs came in, one per input.
// The receiver cannot hold results off; done and result are valid for exactly
// that one cycle.
// Collinear vertices give status collinear with zero center and radius. A center
// outside the 64-bit range or a radius past the 63-bit range is clamped and
// flagged as saturated.
// Reset clears the pipeline valid bits only; words in flight at reset are dropped.
`default_nettype none

module triangle_circumcircle (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire tcirc_pkg::tri_in_t vertices,
    output logic                   done,
    output tcirc_pkg::tri_out_t    result
);

    import tcirc_pkg::*;

    localparam int NUM_W = 100;
    localparam int DEN_W = 67;
    localparam int SQ_N  = 64;

    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic               neg_x;
        logic               neg_y;
        logic               zero_d;
    } div_side_t;

    typedef struct packed {
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic               sat_c;
        logic               rad_ovf;
        logic               zero_d;
    } sq_side_t;

    assign busy = 1'b0;

    // Stage 1: input register.
    logic    v1_reg;
    tri_in_t in1_reg;

    // Stage 2: edge vectors relative to vertex one.
    logic               v2_reg;
    logic signed [32:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [31:0] x1_2_reg, y1_2_reg;
    logic signed [32:0] a1_next, b1_next, a2_next, b2_next;

    assign a1_next = {in1_reg.second_x[31], in1_reg.second_x}
                   - {in1_reg.first_x[31], in1_reg.first_x};
    assign b1_next = {in1_reg.second_y[31], in1_reg.second_y}
                   - {in1_reg.first_y[31], in1_reg.first_y};
    assign a2_next = {in1_reg.third_x[31], in1_reg.third_x}
                   - {in1_reg.first_x[31], in1_reg.first_x};
    assign b2_next = {in1_reg.third_y[31], in1_reg.third_y}
                   - {in1_reg.first_y[31], in1_reg.first_y};

    // Stage 3: squares and cross products.
    logic               v3_reg;
    logic signed [65:0] paa1_reg, pbb1_reg, paa2_reg, pbb2_reg, pa2b1_reg, pa1b2_reg;
    logic signed [32:0] a1_3_reg, b1_3_reg, a2_3_reg, b2_3_reg;
    logic signed [31:0] x1_3_reg, y1_3_reg;

    // Stage 4: squared lengths and determinant.
    logic               v4_reg;
    logic [65:0]        s1_reg, s2_reg;
    logic signed [66:0] d4_reg;
    logic signed [32:0] a1_4_reg, b1_4_reg, a2_4_reg, b2_4_reg;
    logic signed [31:0] x1_4_reg, y1_4_reg;
    logic signed [66:0] s1_wide, s2_wide;

    assign s1_wide = 67'(paa1_reg) + 67'(pbb1_reg);
    assign s2_wide = 67'(paa2_reg) + 67'(pbb2_reg);

    // Stage 5: partial products against the low and high halves of s1 and s2.
    logic               v5_reg;
    logic signed [66:0] bs2l_reg, bs2h_reg, b2s1l_reg, b2s1h_reg;
    logic signed [66:0] as1l_reg, as1h_reg, a1s2l_reg, a1s2h_reg;
    logic signed [66:0] d5_reg;
    logic signed [31:0] x1_5_reg, y1_5_reg;

    // Stage 6: full products.
    logic                v6_reg;
    logic signed [100:0] bs2_reg, b2s1_reg, as1_reg, a1s2_reg;
    logic signed [66:0]  d6_reg;
    logic signed [31:0]  x1_6_reg, y1_6_reg;

    // Stage 7: numerators.
    logic                v7_reg;
    logic signed [100:0] nx_reg, ny_reg;
    logic signed [66:0]  d7_reg;
    logic signed [31:0]  x1_7_reg, y1_7_reg;

    // Stage 8: magnitudes for the rounded division.
    logic               v8_reg;
    logic [NUM_W-1:0]   nmx_reg, nmy_reg;
    logic [DEN_W-1:0]   dm2_reg;
    div_side_t          dside_reg;
    logic [100:0]       anx, any_mag;
    logic [66:0]        ad;

    assign anx     = nx_reg[100] ? 101'(-nx_reg) : nx_reg;
    assign any_mag = ny_reg[100] ? 101'(-ny_reg) : ny_reg;
    assign ad      = d7_reg[66] ? 67'(-d7_reg) : d7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in1_reg   <= vertices;

        a1_reg    <= a1_next;
        b1_reg    <= b1_next;
        a2_reg    <= a2_next;
        b2_reg    <= b2_next;
        x1_2_reg  <= in1_reg.first_x;
        y1_2_reg  <= in1_reg.first_y;

        paa1_reg  <= a1_reg * a1_reg;
        pbb1_reg  <= b1_reg * b1_reg;
        paa2_reg  <= a2_reg * a2_reg;
        pbb2_reg  <= b2_reg * b2_reg;
        pa2b1_reg <= a2_reg * b1_reg;
        pa1b2_reg <= a1_reg * b2_reg;
        a1_3_reg  <= a1_reg;
        b1_3_reg  <= b1_reg;
        a2_3_reg  <= a2_reg;
        b2_3_reg  <= b2_reg;
        x1_3_reg  <= x1_2_reg;
        y1_3_reg  <= y1_2_reg;

        s1_reg    <= s1_wide[65:0];
        s2_reg    <= s2_wide[65:0];
        d4_reg    <= 67'(pa2b1_reg) - 67'(pa1b2_reg);
        a1_4_reg  <= a1_3_reg;
        b1_4_reg  <= b1_3_reg;
        a2_4_reg  <= a2_3_reg;
        b2_4_reg  <= b2_3_reg;
        x1_4_reg  <= x1_3_reg;
        y1_4_reg  <= y1_3_reg;

        bs2l_reg  <= b1_4_reg * $signed({1'b0, s2_reg[32:0]});
        bs2h_reg  <= b1_4_reg * $signed({1'b0, s2_reg[65:33]});
        b2s1l_reg <= b2_4_reg * $signed({1'b0, s1_reg[32:0]});
        b2s1h_reg <= b2_4_reg * $signed({1'b0, s1_reg[65:33]});
        as1l_reg  <= a2_4_reg * $signed({1'b0, s1_reg[32:0]});
        as1h_reg  <= a2_4_reg * $signed({1'b0, s1_reg[65:33]});
        a1s2l_reg <= a1_4_reg * $signed({1'b0, s2_reg[32:0]});
        a1s2h_reg <= a1_4_reg * $signed({1'b0, s2_reg[65:33]});
        d5_reg    <= d4_reg;
        x1_5_reg  <= x1_4_reg;
        y1_5_reg  <= y1_4_reg;

        bs2_reg   <= (101'(bs2h_reg) <<< 33) + 101'(bs2l_reg);
        b2s1_reg  <= (101'(b2s1h_reg) <<< 33) + 101'(b2s1l_reg);
        as1_reg   <= (101'(as1h_reg) <<< 33) + 101'(as1l_reg);
        a1s2_reg  <= (101'(a1s2h_reg) <<< 33) + 101'(a1s2l_reg);
        d6_reg    <= d5_reg;
        x1_6_reg  <= x1_5_reg;
        y1_6_reg  <= y1_5_reg;

        nx_reg    <= bs2_reg - b2s1_reg;
        ny_reg    <= as1_reg - a1s2_reg;
        d7_reg    <= d6_reg;
        x1_7_reg  <= x1_6_reg;
        y1_7_reg  <= y1_6_reg;

        // Rounding to nearest, ties away from zero: (|n| + |d|) / (2|d|).
        nmx_reg          <= NUM_W'(anx + 101'(ad));
        nmy_reg          <= NUM_W'(any_mag + 101'(ad));
        dm2_reg          <= {ad[65:0], 1'b0};
        dside_reg.x1     <= x1_7_reg;
        dside_reg.y1     <= y1_7_reg;
        dside_reg.neg_x  <= nx_reg[100] ^ d7_reg[66];
        dside_reg.neg_y  <= ny_reg[100] ^ d7_reg[66];
        dside_reg.zero_d <= (d7_reg == '0);
    end

    // Division.
    logic             dv_valid;
    logic [NUM_W-1:0] qx, qy;
    div_side_t        dv_side;

    tcirc_div #(
        .NW (NUM_W),
        .DW (DEN_W),
        .SW ($bits(div_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v8_reg),
        .num_a     (nmx_reg),
        .num_b     (nmy_reg),
        .den       (dm2_reg),
        .side_in   (dside_reg),
        .out_valid (dv_valid),
        .quo_a     (qx),
        .quo_b     (qy),
        .side_out  (dv_side)
    );

    // Post stage A: signed offsets, center with clamping, radius range check.
    // The magnitude of each offset is the unsigned quotient itself.
    logic signed [100:0] ox, oy;
    logic signed [101:0] cx_full, cy_full;
    logic                cx_fits, cy_fits;

    assign ox = dv_side.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign oy = dv_side.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    assign cx_full = 102'(dv_side.x1) + 102'(ox);
    assign cy_full = 102'(dv_side.y1) + 102'(oy);
    assign cx_fits = (cx_full[101:63] == '0) || (&cx_full[101:63]);
    assign cy_fits = (cy_full[101:63] == '0) || (&cy_full[101:63]);

    logic        pa_vld_reg;
    sq_side_t    pa_side_reg;
    logic [62:0] axl_reg, ayl_reg;

    // Post stage B: square partial products.
    logic        pb_vld_reg;
    sq_side_t    pb_side_reg;
    logic [61:0] hhx_reg, hhy_reg;
    logic [62:0] hlx_reg, hly_reg;
    logic [63:0] llx_reg, lly_reg;

    // Post stage C: per-axis squares.
    logic         pc_vld_reg;
    sq_side_t     pc_side_reg;
    logic [125:0] vx_reg, vy_reg;

    // Post stage D: sum of squares.
    logic         pd_vld_reg;
    sq_side_t     pd_side_reg;
    logic [127:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_vld_reg <= 1'b0;
            pb_vld_reg <= 1'b0;
            pc_vld_reg <= 1'b0;
            pd_vld_reg <= 1'b0;
        end
        else
        begin
            pa_vld_reg <= dv_valid;
            pb_vld_reg <= pa_vld_reg;
            pc_vld_reg <= pb_vld_reg;
            pd_vld_reg <= pc_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_side_reg.cx      <= cx_fits ? cx_full[63:0]
                             : (cx_full[101] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
        pa_side_reg.cy      <= cy_fits ? cy_full[63:0]
                             : (cy_full[101] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
        pa_side_reg.sat_c   <= !cx_fits || !cy_fits;
        pa_side_reg.rad_ovf <= (|qx[NUM_W-1:63]) || (|qy[NUM_W-1:63]);
        pa_side_reg.zero_d  <= dv_side.zero_d;
        axl_reg             <= qx[62:0];
        ayl_reg             <= qy[62:0];

        hhx_reg     <= axl_reg[62:32] * axl_reg[62:32];
        hlx_reg     <= axl_reg[62:32] * axl_reg[31:0];
        llx_reg     <= axl_reg[31:0] * axl_reg[31:0];
        hhy_reg     <= ayl_reg[62:32] * ayl_reg[62:32];
        hly_reg     <= ayl_reg[62:32] * ayl_reg[31:0];
        lly_reg     <= ayl_reg[31:0] * ayl_reg[31:0];
        pb_side_reg <= pa_side_reg;

        // The high and low squares do not overlap, so they simply concatenate.
        vx_reg      <= {hhx_reg, llx_reg} + (126'(hlx_reg) << 33);
        vy_reg      <= {hhy_reg, lly_reg} + (126'(hly_reg) << 33);
        pc_side_reg <= pb_side_reg;

        v_reg       <= 128'(vx_reg) + 128'(vy_reg);
        pd_side_reg <= pc_side_reg;
    end

    // Square root: one root bit per stage, two radicand bits consumed per stage.
    logic [SQ_N-1:0] sq_vld_reg;
    logic [65:0]     rem_reg   [SQ_N];
    logic [63:0]     root_reg  [SQ_N];
    logic [127:0]    rad_reg   [SQ_N];
    sq_side_t        sside_reg [SQ_N];

    logic [SQ_N-1:0] sq_vld_src;
    logic [65:0]     rem_src   [SQ_N];
    logic [63:0]     root_src  [SQ_N];
    logic [127:0]    rad_src   [SQ_N];
    sq_side_t        sside_src [SQ_N];

    logic [67:0]     sq_t      [SQ_N];
    logic [67:0]     sq_trial  [SQ_N];
    logic            sq_ge     [SQ_N];
    logic [65:0]     rem_next  [SQ_N];
    logic [63:0]     root_next [SQ_N];
    logic [127:0]    rad_next  [SQ_N];

    always_comb
    begin
        sq_vld_src[0] = pd_vld_reg;
        rem_src[0]    = '0;
        root_src[0]   = '0;
        rad_src[0]    = v_reg;
        sside_src[0]  = pd_side_reg;
        for (int k = 1; k < SQ_N; k++)
        begin
            sq_vld_src[k] = sq_vld_reg[k-1];
            rem_src[k]    = rem_reg[k-1];
            root_src[k]   = root_reg[k-1];
            rad_src[k]    = rad_reg[k-1];
            sside_src[k]  = sside_reg[k-1];
        end
        for (int k = 0; k < SQ_N; k++)
        begin
            sq_t[k]      = {rem_src[k], rad_src[k][127:126]};
            sq_trial[k]  = {2'b00, root_src[k], 2'b01};
            sq_ge[k]     = sq_t[k] >= sq_trial[k];
            rem_next[k]  = sq_ge[k] ? 66'(sq_t[k] - sq_trial[k]) : sq_t[k][65:0];
            root_next[k] = {root_src[k][62:0], sq_ge[k]};
            rad_next[k]  = {rad_src[k][125:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= '0;
        end
        else
        begin
            sq_vld_reg <= sq_vld_src;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQ_N; k++)
        begin
            rem_reg[k]   <= rem_next[k];
            root_reg[k]  <= root_next[k];
            rad_reg[k]   <= rad_next[k];
            sside_reg[k] <= sside_src[k];
        end
    end

    // Output stage.
    sq_side_t    fin_side;
    logic [63:0] fin_root;
    logic        rad_sat;
    tri_out_t    result_next;
    logic        done_reg;
    tri_out_t    result_reg;

    assign fin_side = sside_reg[SQ_N-1];
    assign fin_root = root_reg[SQ_N-1];
    assign rad_sat  = fin_side.rad_ovf || fin_root[63];

    always_comb
    begin
        if (fin_side.zero_d)
        begin
            result_next.center_x = '0;
            result_next.center_y = '0;
            result_next.radius   = '0;
            result_next.status   = STATUS_COLLINEAR;
        end
        else
        begin
            result_next.center_x = fin_side.cx;
            result_next.center_y = fin_side.cy;
            result_next.radius   = rad_sat ? {63{1'b1}} : fin_root[62:0];
            result_next.status   = (rad_sat || fin_side.sat_c) ? STATUS_SATURATED
                                                               : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sq_vld_reg[SQ_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

@@ tb/tb_triangle_circumcircle.sv @@
// Testbench for the triangle circumcircle block: directed and random triangles.
`default_nettype none

module tb_triangle_circumcircle;
    import tcirc_pkg::*;

    localparam int LATENCY = 176;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    tri_in_t vertices = '0;
    logic done;
    tri_out_t result;

    tri_out_t expected_circles[$];
    int errors = 0;
    bit burst_mode = 1'b0;

    triangle_circumcircle dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .vertices(vertices),
        .done(done),
        .result(result)
    );

    always #6 clk = ~clk;

    // Divide n by 2d, rounding to nearest with ties away from zero.
    function automatic logic signed [127:0] round_half_quotient(
        logic signed [127:0] n, logic signed [127:0] d);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        nm = n[127] ? -n : n;
        dm = d[127] ? -d : d;
        q = (nm + dm) / (dm << 1);
        return (n[127] != d[127]) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] clamp64(logic signed [127:0] v, ref bit sat);
        if (v > 128'sh7FFF_FFFF_FFFF_FFFF)
        begin
            sat = 1'b1;
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        if (v < -128'sh8000_0000_0000_0000)
        begin
            sat = 1'b1;
            return 64'h8000_0000_0000_0000;
        end
        return v[63:0];
    endfunction

    function automatic tri_out_t circumcircle(tri_in_t t);
        tri_out_t r;
        logic signed [127:0] x1, y1, a1, b1, a2, b2, s1, s2, det, ox, oy;
        logic [127:0] ax, ay, sq, root, trial;
        bit sat;
        x1 = t.first_x;
        y1 = t.first_y;
        a1 = 128'(t.second_x) - x1;
        b1 = 128'(t.second_y) - y1;
        a2 = 128'(t.third_x) - x1;
        b2 = 128'(t.third_y) - y1;
        s1 = a1 * a1 + b1 * b1;
        s2 = a2 * a2 + b2 * b2;
        det = a2 * b1 - a1 * b2;
        sat = 1'b0;
        r = '0;
        if (det == 0)
        begin
            r.status = STATUS_COLLINEAR;
            return r;
        end
        ox = round_half_quotient(b1 * s2 - b2 * s1, det);
        oy = round_half_quotient(a2 * s1 - a1 * s2, det);
        r.center_x = clamp64(x1 + ox, sat);
        r.center_y = clamp64(y1 + oy, sat);
        ax = ox[127] ? -ox : ox;
        ay = oy[127] ? -oy : oy;
        if (ax >= 128'h1 << 63 || ay >= 128'h1 << 63)
        begin
            sat = 1'b1;
            r.radius = '1;
        end
        else
        begin
            sq = ax * ax + ay * ay;
            root = 0;
            for (int i = 63; i >= 0; i--)
            begin
                trial = root | (128'h1 << i);
                if (sq >= trial * trial)
                    root = trial;
            end
            if (root > 128'h7FFF_FFFF_FFFF_FFFF)
            begin
                sat = 1'b1;
                r.radius = '1;
            end
            else
                r.radius = root[62:0];
        end
        r.status = sat ? STATUS_SATURATED : STATUS_OK;
        return r;
    endfunction

    task automatic send_triangle(tri_in_t t);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        vertices <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_circles.push_back(circumcircle(t));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_circles.size() != 0)
            @(posedge clk);
    endtask

    function automatic tri_in_t make_tri(int x1, int y1, int x2, int y2, int x3, int y3);
        tri_in_t t;
        t.first_x = x1;
        t.first_y = y1;
        t.second_x = x2;
        t.second_y = y2;
        t.third_x = x3;
        t.third_y = y3;
        return t;
    endfunction

    function automatic int rand_coord(int sel);
        case (sel)
            0: return $urandom;
            1: return $signed($urandom_range(0, 2000)) - 1000;
            2: return ($signed($urandom_range(0, 200)) - 100) <<< 16;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                                 : -32'sh8000_0000 + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic test_directed();
        int mx;
        int mn;
        mx = 32'sh7FFF_FFFF;
        mn = -32'sh8000_0000;
        send_triangle(make_tri(0, 0, 65536, 0, 0, 65536));
        send_triangle(make_tri(0, 0, 1, 0, 0, 1));
        send_triangle(make_tri(0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(1, 1, 2, 2, 3, 3));
        send_triangle(make_tri(5, 7, 5, 7, 100, 3));
        send_triangle(make_tri(mn, mn, mx, mx, mn, mx));
        send_triangle(make_tri(mx, mx, mn, mn, mx, mn));
        send_triangle(make_tri(mn, mn, mx, mx, mx, mx - 1));
        send_triangle(make_tri(mn, mn, mx, mx, mx - 1, mx));
        send_triangle(make_tri(mn, 0, mx, 1, 0, 0));
        send_triangle(make_tri(0, 0, 3, 0, 0, 1));
        send_triangle(make_tri(0, 0, -3, 0, 0, -1));
        send_triangle(make_tri(mx, mn, mn, mx, 0, 1));
        send_triangle(make_tri(-1, -1, -1, -1, -1, -1));
        send_triangle(make_tri(0, 0, mx, 0, mx, 1));
        send_triangle(make_tri(0, 0, mn, 1, mn, 2));
    endtask

    task automatic test_random(int count);
        tri_in_t t;
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 3);
            t = make_tri(rand_coord(kind), rand_coord(kind), rand_coord(kind),
                         rand_coord(kind), rand_coord(kind), rand_coord(kind));
            // Force degenerate shapes (third vertex on the second) now and then.
            if ($urandom_range(0, 9) == 0)
            begin
                t.third_x = t.second_x;
                t.third_y = t.second_y;
            end
            send_triangle(t);
        end
    endtask

    task automatic test_back_to_back(int count);
        burst_mode = 1'b1;
        test_random(count);
        burst_mode = 1'b0;
    endtask

    always @(posedge clk)
    begin
        tri_out_t exp_w;
        if (done)
        begin
            if (expected_circles.size() == 0)
            begin
                $error("result word with no triangle outstanding");
                errors++;
            end
            else
            begin
                exp_w = expected_circles.pop_front();
                if (result.center_x !== exp_w.center_x)
                begin
                    $error("center_x expected %0d actual %0d", exp_w.center_x, result.center_x);
                    errors++;
                end
                if (result.center_y !== exp_w.center_y)
                begin
                    $error("center_y expected %0d actual %0d", exp_w.center_y, result.center_y);
                    errors++;
                end
                if (result.radius !== exp_w.radius)
                begin
                    $error("radius expected %0d actual %0d", exp_w.radius, result.radius);
                    errors++;
                end
                if (result.status !== exp_w.status)
                begin
                    $error("status expected %0d actual %0d", exp_w.status, result.status);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        drain();
        test_random(300);
        // Hold off until the pipeline has emptied, then resume.
        drain();
        test_back_to_back(100);
        test_random(250);
        drain();
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
